FILE: hdl/bqeq_pkg.sv
// ============================================================================
// Biquad equalizer package
// Shared types, codes and constants of the biquad cascade equalizer.
// ============================================================================
package bqeq_pkg;

  // Default sizes of the cascade.
  localparam int BANDS_DEF    = 7;
  localparam int CHANNELS_DEF = 2;

  // Widths fixed by the word formats.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam int COEF_W    = 32;
  localparam int SIG_W     = 32;
  localparam int PCM_W     = 16;
  localparam int ACC_W     = 40;
  localparam int NSLOT     = 5;

  // Reset value of the preamp gain, unity in Q4.12.
  localparam logic [15:0] GAIN_UNITY = 16'd4096;

  // Input word modes. The last one is unused and the word is dropped.
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 8'd1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_RUN,
    ST_OUT
  } state_e;

  // Coefficient write and history clear broadcast to every cell.
  typedef struct packed {
    logic                     we;
    logic [2:0]               band;
    logic [2:0]               slot;
    logic signed [COEF_W-1:0] value;
    logic                     clear;
  } cell_ctrl_t;

endpackage

FILE: hdl/bqeq_in_if.sv
// ============================================================================
// Equalizer input channel
// Valid/ready channel carrying one input word of the equalizer.
// ============================================================================
interface bqeq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] sample_in;
  logic               channel;
  logic               last_in_block;
  logic [2:0]         coef_band;
  logic [2:0]         coef_slot;
  logic signed [31:0] coef_value;

  modport source (output valid, mode, sample_in, channel, last_in_block,
                  coef_band, coef_slot, coef_value, input ready);
  modport sink   (input valid, mode, sample_in, channel, last_in_block,
                  coef_band, coef_slot, coef_value, output ready);
endinterface

FILE: hdl/bqeq_out_if.sv
// ============================================================================
// Equalizer output channel
// Valid/ready channel carrying one equalized sample word.
// ============================================================================
interface bqeq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               channel_out;
  logic               last_out;

  modport source (output valid, sample_out, channel_out, last_out, input ready);
  modport sink   (input valid, sample_out, channel_out, last_out, output ready);
endinterface

FILE: hdl/bqeq_cfg_if.sv
// ============================================================================
// Equalizer configuration channel
// Valid/ready write channel carrying a register index and write data.
// ============================================================================
interface bqeq_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/bqeq_cell.sv
// ============================================================================
// Biquad cell
// One direct-form-1 band: holds its five coefficients and the history of
// every channel, runs five products through one multiplier and hands the
// band output to the next cell.
// ============================================================================
module bqeq_cell #(
  parameter int CHANNELS = bqeq_pkg::CHANNELS_DEF,
  parameter int CH_W     = 1,
  parameter int IDX      = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqeq_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                start_i,
  input  logic signed [bqeq_pkg::SIG_W-1:0]   y_i,
  input  logic [CH_W-1:0]                     ch_i,
  output logic                                done_o,
  output logic signed [bqeq_pkg::SIG_W-1:0]   y_o,
  output logic [CH_W-1:0]                     ch_o,
  output logic                                busy_o
);
  import bqeq_pkg::*;

  localparam logic [2:0] LAST_PROD = 3'd4;
  localparam logic [2:0] SAT_STEP  = 3'd6;

  logic signed [COEF_W-1:0] coef_q [NSLOT];
  logic signed [SIG_W-1:0]  hist_q [CHANNELS][4];
  logic                     busy_q;
  logic [2:0]               cnt_q;
  logic signed [SIG_W-1:0]  yin_q;
  logic [CH_W-1:0]          ch_q;
  logic signed [63:0]       prod_q;
  logic                     sub_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     done_q;
  logic signed [SIG_W-1:0]  yout_q;

  logic signed [SIG_W-1:0]  op;
  logic signed [COEF_W-1:0] cf;
  logic signed [35:0]       sh;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [SIG_W-1:0]  sat;

  // Operand and coefficient of the current product.
  always_comb begin
    case (cnt_q)
      3'd0:    op = yin_q;
      3'd1:    op = hist_q[ch_q][0];
      3'd2:    op = hist_q[ch_q][1];
      3'd3:    op = hist_q[ch_q][2];
      3'd4:    op = hist_q[ch_q][3];
      default: op = '0;
    endcase
    cf = (cnt_q <= LAST_PROD) ? coef_q[cnt_q] : '0;
  end

  // Floor shift of the registered product and accumulation.
  always_comb begin
    sh    = prod_q[63:28];
    acc_d = acc_q;
    if (pv_q) begin
      if (sub_q) begin
        acc_d = acc_q - {{(ACC_W-36){sh[35]}}, sh};
      end else begin
        acc_d = acc_q + {{(ACC_W-36){sh[35]}}, sh};
      end
    end
  end

  // Saturation of the band sum to the signal format.
  always_comb begin
    if (acc_q > ACC_W'(64'sh7FFF_FFFF)) begin
      sat = 32'sh7FFF_FFFF;
    end else if (acc_q < -ACC_W'(64'sh8000_0000)) begin
      sat = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      sat = acc_q[SIG_W-1:0];
    end
  end

  // Coefficient storage, written by broadcast.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we && (32'(ctrl_i.band) == IDX) && (ctrl_i.slot < 3'(NSLOT))) begin
      coef_q[ctrl_i.slot] <= ctrl_i.value;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      yin_q <= y_i;
      ch_q  <= ch_i;
    end
    prod_q <= cf * op;
    sub_q  <= (cnt_q >= 3'd3);
    acc_q  <= start_i ? '0 : acc_d;
    if (busy_q && cnt_q == SAT_STEP) begin
      yout_q <= sat;
    end
  end

  // Sequencing and history. A clear takes the place of a history update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < 4; k++) begin
          hist_q[c][k] <= '0;
        end
      end
    end else begin
      pv_q   <= busy_q && (cnt_q <= LAST_PROD);
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == SAT_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          if (!ctrl_i.clear) begin
            hist_q[ch_q][1] <= hist_q[ch_q][0];
            hist_q[ch_q][0] <= yin_q;
            hist_q[ch_q][3] <= hist_q[ch_q][2];
            hist_q[ch_q][2] <= sat;
          end
        end
        cnt_q <= cnt_q + 3'd1;
      end
      if (ctrl_i.clear) begin
        for (int c = 0; c < CHANNELS; c++) begin
          for (int k = 0; k < 4; k++) begin
            hist_q[c][k] <= '0;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign y_o    = yout_q;
  assign ch_o   = ch_q;
  assign busy_o = busy_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("cell started while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("cell did not start");
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q && $past(cnt_q) == SAT_STEP) else $error("early done");
`endif

endmodule

FILE: hdl/biquad_cascade_equalizer.sv
// ============================================================================
// Biquad cascade equalizer
// Preamp and a chain of direct-form-1 biquad cells, one per band.
// ============================================================================
// An enabled sample word goes from acceptance through the preamp product
// and then through each band cell in turn, where each cell runs its five
// products through its own single 32x32 multiplier, finishes the sum,
// saturates it and hands the band output on; the last hand-over also loads
// the PCM value truncated and saturated, and the output register is loaded
// from it once that register is free. Only one sample is in the cascade at a
// time; the next word is taken in the cycle after the result reaches the
// output register, and a result that still waits in the output register
// holds the next one and so stops the input. Coefficient and clear words
// leave the controller idle, and pass-through words go straight to the
// output register. No clearing pass is needed after reset.
module biquad_cascade_equalizer #(
  parameter int BANDS    = bqeq_pkg::BANDS_DEF,
  parameter int CHANNELS = bqeq_pkg::CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bqeq_in_if.sink    in_i,
  bqeq_out_if.source out_o,
  bqeq_cfg_if.sink   cfg_i
);
  import bqeq_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_e                  state_q, state_d;
  logic                    enable_q;
  logic [15:0]             gain_q;
  logic signed [PCM_W-1:0] x_q;
  logic                    ch_q;
  logic                    last_q;
  logic signed [PCM_W-1:0] res_q;
  logic                    ov_q;
  logic signed [PCM_W-1:0] osmp_q;
  logic                    och_q;
  logic                    olast_q;

  logic                    in_acc;
  logic                    cfg_acc;
  logic                    out_load;
  cell_ctrl_t              ctrl;
  logic signed [SIG_W:0]   pre_prod;
  logic                    start   [BANDS+1];
  logic signed [SIG_W-1:0] y       [BANDS+1];
  logic [CH_W-1:0]         chx     [BANDS+1];
  logic [BANDS-1:0]        busy;
  logic signed [SIG_W-1:0] fin;
  logic signed [19:0]      q;
  logic signed [PCM_W-1:0] qsat;

  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign out_load = (state_q == ST_OUT) && (!ov_q || out_o.ready);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Broadcast to the cells.
  always_comb begin
    ctrl.we    = in_acc && (in_i.mode == MODE_COEF);
    ctrl.band  = in_i.coef_band;
    ctrl.slot  = in_i.coef_slot;
    ctrl.value = in_i.coef_value;
    ctrl.clear = (in_acc && (in_i.mode == MODE_CLEAR)) ||
                 (cfg_acc && (cfg_i.index == CFG_ENABLE) && cfg_i.data[0]);
  end

  // Preamp product feeds the first cell. It always fits the signal format.
  assign pre_prod = x_q * $signed({1'b0, gain_q});
  assign start[0] = (state_q == ST_PRE);
  assign y[0]     = pre_prod[SIG_W-1:0];
  assign chx[0]   = (CHANNELS > 1) ? CH_W'(ch_q) : '0;

  // Chain of band cells.
  for (genvar b = 0; b < BANDS; b++) begin : g_band
    bqeq_cell #(
      .CHANNELS (CHANNELS),
      .CH_W     (CH_W),
      .IDX      (b)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .start_i (start[b]),
      .y_i     (y[b]),
      .ch_i    (chx[b]),
      .done_o  (start[b+1]),
      .y_o     (y[b+1]),
      .ch_o    (chx[b+1]),
      .busy_o  (busy[b])
    );
  end

  // Truncate toward zero to PCM units, then saturate.
  always_comb begin
    fin = y[BANDS];
    if (fin[SIG_W-1]) begin
      fin = fin + 32'sd4095;
    end
    q = fin[SIG_W-1:12];
    if (q > 20'sd32767) begin
      qsat = 16'sh7FFF;
    end else if (q < -20'sd32768) begin
      qsat = 16'sh8000;
    end else begin
      qsat = q[PCM_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.mode == MODE_SAMPLE) begin
          state_d = enable_q ? ST_PRE : ST_OUT;
        end
      end
      ST_PRE:  state_d = ST_RUN;
      ST_RUN: begin
        if (start[BANDS]) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      enable_q <= 1'b0;
      gain_q   <= GAIN_UNITY;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc && cfg_i.index == CFG_ENABLE) begin
        enable_q <= cfg_i.data[0];
      end
      if (cfg_acc && cfg_i.index == CFG_GAIN) begin
        gain_q <= cfg_i.data[15:0];
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= in_i.sample_in;
      ch_q   <= in_i.channel;
      last_q <= in_i.last_in_block;
      res_q  <= in_i.sample_in;
    end else if (state_q == ST_RUN && start[BANDS]) begin
      res_q <= qsat;
    end
    if (out_load) begin
      osmp_q  <= res_q;
      och_q   <= ch_q;
      olast_q <= last_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.sample_out  = osmp_q;
  assign out_o.channel_out = och_q;
  assign out_o.last_out    = olast_q;

`ifndef SYNTHESIS
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start[BANDS] |-> state_q == ST_RUN) else $error("cascade done outside run");
  a_one_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(busy)) else $error("more than one cell busy");
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.mode == MODE_SAMPLE && !enable_q) |=> state_q == ST_OUT)
    else $error("bypass word not sent to output");
`endif

endmodule
